// ----- rtl/mrss_pkg.sv -----
// shared types, constants and register indexes of the motion ramp step scheduler
// no dependencies
package mrss_pkg;

    localparam int unsigned NUM_AXES    = 5;
    localparam int unsigned TICK_MS     = 40;
    localparam int unsigned RAMP_EXTRA  = 3;
    localparam logic [31:0] ELAPSED_MAX = 32'hffff_ffff;
    localparam logic [3:0]  STAGE_MAX   = 4'd15;
    localparam logic [1:0]  AXIS_NONE   = 2'd3;

    typedef enum logic [2:0] {
        CFG_ROTATE_MODE       = 3'd0,
        CFG_ROTATE_AXIS       = 3'd1,
        CFG_ROTATE_STAGES     = 3'd2,
        CFG_ROTATE_FULL_CLOCK = 3'd3,
        CFG_RAMP_STEPS_TOTAL  = 3'd4,
        CFG_RAMP_DISABLE      = 3'd5,
        CFG_DECEL_MARGIN      = 3'd6,
        CFG_MAX_PULSES        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        rotate_mode;
        logic [1:0]  rotate_axis;
        logic [4:0]  rotate_stages;
        logic [15:0] rotate_full_clock;
        logic [7:0]  ramp_steps_total;
        logic        ramp_disable;
        logic [31:0] decel_margin;
        logic [31:0] max_pulses;
    } cfg_t;

    typedef struct packed {
        logic                         action;
        logic [NUM_AXES-1:0][31:0]    pulses;
        logic [NUM_AXES-1:0][31:0]    targets;
    } item_t;

    typedef struct packed {
        logic [31:0] elapsed_time;
        logic [7:0]  step_number;
        logic [3:0]  stage_index;
    } state_t;

    typedef struct packed {
        logic        motor_start;
        logic        speed_update;
        logic [7:0]  speed_step;
        logic        clock_update;
        logic [1:0]  clock_axis;
        logic [15:0] clock_value;
        logic [31:0] elapsed_ms;
    } result_t;

endpackage

// ----- rtl/mrss_step.sv -----
// next-state and result logic for one tick or start-move transaction
// depends on mrss_pkg
module mrss_step (
    input  mrss_pkg::cfg_t    cfg,
    input  mrss_pkg::state_t  state,
    input  mrss_pkg::item_t   item,
    output mrss_pkg::state_t  state_next,
    output mrss_pkg::result_t result
);

    logic [4:0]  stage_lim;
    logic [3:0]  stage_inc;
    logic [4:0]  shift_amt;
    logic [31:0] elapsed_inc;
    logic [31:0] window;
    logic [31:0] watched;
    logic [31:0] thresh;

    always_comb begin
        stage_lim   = cfg.rotate_stages - 5'd1;
        stage_inc   = state.stage_index + 4'd1;
        shift_amt   = stage_lim - {1'b0, stage_inc};
        elapsed_inc = state.elapsed_time;
        if (state.elapsed_time < (mrss_pkg::ELAPSED_MAX - 32'(mrss_pkg::TICK_MS))) begin
            elapsed_inc = state.elapsed_time + 32'(mrss_pkg::TICK_MS);
        end
        window = (32'(cfg.ramp_steps_total) + 32'(mrss_pkg::RAMP_EXTRA))
                 * 32'(mrss_pkg::TICK_MS);
        // first axis whose target matches the move maximum
        watched = '0;
        for (int k = mrss_pkg::NUM_AXES - 1; k >= 0; k--) begin
            if (item.targets[k] == cfg.max_pulses) begin
                watched = item.pulses[k];
            end
        end
        thresh = (cfg.decel_margin > cfg.max_pulses) ? '0
                                                     : cfg.max_pulses - cfg.decel_margin;

        state_next = state;
        result     = '0;

        if (item.action) begin
            state_next = '0;
        end else if (cfg.rotate_mode) begin
            if (cfg.rotate_axis != mrss_pkg::AXIS_NONE && cfg.rotate_stages != 5'd0 &&
                {1'b0, state.stage_index} < stage_lim &&
                state.stage_index < mrss_pkg::STAGE_MAX) begin
                state_next.stage_index = stage_inc;
                result.clock_update    = 1'b1;
                result.clock_axis      = cfg.rotate_axis;
                result.clock_value     = cfg.rotate_full_clock >> shift_amt;
            end
            result.motor_start = 1'b1;
        end else begin
            state_next.elapsed_time = elapsed_inc;
            if (elapsed_inc < window) begin
                if (!cfg.ramp_disable && state.step_number < cfg.ramp_steps_total) begin
                    state_next.step_number = state.step_number + 8'd1;
                    result.speed_update    = 1'b1;
                    result.motor_start     = 1'b1;
                end
            end else begin
                if (watched >= thresh && !cfg.ramp_disable && state.step_number > 8'd1) begin
                    state_next.step_number = state.step_number - 8'd1;
                    result.speed_update    = 1'b1;
                    result.motor_start     = 1'b1;
                end
            end
        end

        result.speed_step = state_next.step_number;
        result.elapsed_ms = state_next.elapsed_time;
    end

endmodule

// ----- rtl/motion_ramp_step_scheduler_core.sv -----
// top level of the motion ramp step scheduler: ports, config registers, pipeline
// depends on mrss_pkg and mrss_step
//
// One result transaction per input transaction, in order. A transaction enters an
// input register, passes through one stage of compare/add logic into the result
// register, and is presented on the output from there; a new one is taken every
// cycle while the result side keeps up. Elapsed time, speed step and rotate stage
// are held in the block and advance only as each transaction moves
// into the result register. A start move (action 1) clears that state and returns
// an all-zero result. Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data
// and should only change while no transaction is in flight.
module motion_ramp_step_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_pulses_x,
    input  logic [31:0] s_pulses_y,
    input  logic [31:0] s_pulses_z,
    input  logic [31:0] s_pulses_a,
    input  logic [31:0] s_pulses_b,
    input  logic [31:0] s_target_x,
    input  logic [31:0] s_target_y,
    input  logic [31:0] s_target_z,
    input  logic [31:0] s_target_a,
    input  logic [31:0] s_target_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_motor_start,
    output logic        m_speed_update,
    output logic [7:0]  m_speed_step,
    output logic        m_clock_update,
    output logic [1:0]  m_clock_axis,
    output logic [15:0] m_clock_value,
    output logic [31:0] m_elapsed_ms
);

    mrss_pkg::cfg_t    cfg_reg;
    mrss_pkg::state_t  state_reg;
    mrss_pkg::state_t  state_next;
    mrss_pkg::item_t   item_reg;
    mrss_pkg::item_t   item_in;
    mrss_pkg::result_t result_next;
    mrss_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              s_accept;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        item_in.action     = s_action;
        item_in.pulses[0]  = s_pulses_x;
        item_in.pulses[1]  = s_pulses_y;
        item_in.pulses[2]  = s_pulses_z;
        item_in.pulses[3]  = s_pulses_a;
        item_in.pulses[4]  = s_pulses_b;
        item_in.targets[0] = s_target_x;
        item_in.targets[1] = s_target_y;
        item_in.targets[2] = s_target_z;
        item_in.targets[3] = s_target_a;
        item_in.targets[4] = s_target_b;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotate_mode       <= 1'b0;
            cfg_reg.rotate_axis       <= 2'd0;
            cfg_reg.rotate_stages     <= 5'd4;
            cfg_reg.rotate_full_clock <= 16'd6666;
            cfg_reg.ramp_steps_total  <= 8'd0;
            cfg_reg.ramp_disable      <= 1'b0;
            cfg_reg.decel_margin      <= 32'd0;
            cfg_reg.max_pulses        <= 32'd0;
        end else if (cfg_wr_en) begin
            unique case (mrss_pkg::cfg_index_t'(cfg_index))
                mrss_pkg::CFG_ROTATE_MODE:       cfg_reg.rotate_mode       <= cfg_wr_data[0];
                mrss_pkg::CFG_ROTATE_AXIS:       cfg_reg.rotate_axis       <= cfg_wr_data[1:0];
                mrss_pkg::CFG_ROTATE_STAGES:     cfg_reg.rotate_stages     <= cfg_wr_data[4:0];
                mrss_pkg::CFG_ROTATE_FULL_CLOCK: cfg_reg.rotate_full_clock <= cfg_wr_data[15:0];
                mrss_pkg::CFG_RAMP_STEPS_TOTAL:  cfg_reg.ramp_steps_total  <= cfg_wr_data[7:0];
                mrss_pkg::CFG_RAMP_DISABLE:      cfg_reg.ramp_disable      <= cfg_wr_data[0];
                mrss_pkg::CFG_DECEL_MARGIN:      cfg_reg.decel_margin      <= cfg_wr_data;
                mrss_pkg::CFG_MAX_PULSES:        cfg_reg.max_pulses        <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    mrss_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_motor_start  = result_reg.motor_start;
    assign m_speed_update = result_reg.speed_update;
    assign m_speed_step   = result_reg.speed_step;
    assign m_clock_update = result_reg.clock_update;
    assign m_clock_axis   = result_reg.clock_axis;
    assign m_clock_value  = result_reg.clock_value;
    assign m_elapsed_ms   = result_reg.elapsed_ms;

    a_clock_implies_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clock_update |-> m_motor_start)
        else $error("clock update without motor start");

    a_speed_not_in_rotate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_speed_update |-> m_motor_start && !m_clock_update)
        else $error("speed update mixed with clock update");

    a_idle_clock_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_clock_update |-> m_clock_value == 16'd0 && m_clock_axis == 2'd0)
        else $error("clock fields set without clock update");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg)
        else $error("input stalled with free pipeline");

endmodule

// ----- tb/motion_ramp_step_scheduler_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for motion_ramp_step_scheduler_core: directed ramps, then random moves
// depends on mrss_pkg and the motion_ramp_step_scheduler_core rtl
module motion_ramp_step_scheduler_core_tb;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 72;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    mrss_pkg::cfg_index_t cfg_idx = mrss_pkg::CFG_ROTATE_MODE;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    mrss_pkg::item_t      drv_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_motor_start;
    logic                 m_speed_update;
    logic [7:0]           m_speed_step;
    logic                 m_clock_update;
    logic [1:0]           m_clock_axis;
    logic [15:0]          m_clock_value;
    logic [31:0]          m_elapsed_ms;

    // scheduler state and registers as the block should hold them
    mrss_pkg::cfg_t       cfg_mirror;
    logic [31:0]          run_elapsed = '0;
    logic [7:0]           run_step = '0;
    logic [3:0]           run_stage = '0;

    mrss_pkg::item_t      tick_q[$];
    mrss_pkg::result_t    ramp_result_q[$];
    int                   n_queued = 0;
    int                   n_offered = 0;
    int                   n_accepted = 0;
    int                   n_errors = 0;
    int                   send_idle_pct = 33;
    int                   recv_idle_pct = 48;
    int                   hold_req_cnt = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   cycle_cnt = 0;

    motion_ramp_step_scheduler_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_idx),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (drv_item.action),
        .s_pulses_x     (drv_item.pulses[0]),
        .s_pulses_y     (drv_item.pulses[1]),
        .s_pulses_z     (drv_item.pulses[2]),
        .s_pulses_a     (drv_item.pulses[3]),
        .s_pulses_b     (drv_item.pulses[4]),
        .s_target_x     (drv_item.targets[0]),
        .s_target_y     (drv_item.targets[1]),
        .s_target_z     (drv_item.targets[2]),
        .s_target_a     (drv_item.targets[3]),
        .s_target_b     (drv_item.targets[4]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_motor_start  (m_motor_start),
        .m_speed_update (m_speed_update),
        .m_speed_step   (m_speed_step),
        .m_clock_update (m_clock_update),
        .m_clock_axis   (m_clock_axis),
        .m_clock_value  (m_clock_value),
        .m_elapsed_ms   (m_elapsed_ms)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic mrss_pkg::result_t schedule_tick(mrss_pkg::item_t it);
        mrss_pkg::result_t r;
        logic [31:0]       window;
        logic [31:0]       watched;
        logic [31:0]       thresh;
        logic [31:0]       sh;
        logic              found;
        r = '0;
        watched = '0;
        found = 1'b0;
        if (it.action) begin
            run_elapsed = '0;
            run_step = '0;
            run_stage = '0;
        end else if (cfg_mirror.rotate_mode) begin
            if (cfg_mirror.rotate_axis != mrss_pkg::AXIS_NONE &&
                cfg_mirror.rotate_stages >= 5'd1 &&
                32'(run_stage) < 32'(cfg_mirror.rotate_stages) - 32'd1 &&
                run_stage < mrss_pkg::STAGE_MAX) begin
                run_stage = run_stage + 4'd1;
                sh = 32'(cfg_mirror.rotate_stages) - 32'(run_stage) - 32'd1;
                r.clock_update = 1'b1;
                r.clock_axis = cfg_mirror.rotate_axis;
                r.clock_value = 16'(32'(cfg_mirror.rotate_full_clock) >> sh);
            end
            r.motor_start = 1'b1;
        end else begin
            if (run_elapsed < mrss_pkg::ELAPSED_MAX - 32'(mrss_pkg::TICK_MS))
                run_elapsed = run_elapsed + 32'(mrss_pkg::TICK_MS);
            window = (32'(cfg_mirror.ramp_steps_total) + 32'(mrss_pkg::RAMP_EXTRA))
                     * 32'(mrss_pkg::TICK_MS);
            if (run_elapsed < window) begin
                if (!cfg_mirror.ramp_disable && run_step < cfg_mirror.ramp_steps_total) begin
                    run_step = run_step + 8'd1;
                    r.speed_update = 1'b1;
                    r.motor_start = 1'b1;
                end
            end else begin
                for (int k = 0; k < mrss_pkg::NUM_AXES; k++) begin
                    if (!found && it.targets[k] == cfg_mirror.max_pulses) begin
                        watched = it.pulses[k];
                        found = 1'b1;
                    end
                end
                thresh = (cfg_mirror.decel_margin > cfg_mirror.max_pulses) ? 32'd0 :
                         cfg_mirror.max_pulses - cfg_mirror.decel_margin;
                if (watched >= thresh && !cfg_mirror.ramp_disable && run_step > 8'd1) begin
                    run_step = run_step - 8'd1;
                    r.speed_update = 1'b1;
                    r.motor_start = 1'b1;
                end
            end
        end
        r.speed_step = run_step;
        r.elapsed_ms = run_elapsed;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // driver: next transaction presented once the previous one has been taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (n_accepted == n_offered) begin
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item <= tick_q.pop_front();
                s_valid <= 1'b1;
                n_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge aclk) begin
        mrss_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                ramp_result_q.push_back(schedule_tick(drv_item));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (ramp_result_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, elapsed_ms 0x%0h",
                             $time, m_elapsed_ms);
                    n_errors++;
                end else begin
                    want = ramp_result_q.pop_front();
                    compare_field("motor_start", 32'(want.motor_start), 32'(m_motor_start));
                    compare_field("speed_update", 32'(want.speed_update), 32'(m_speed_update));
                    compare_field("speed_step", 32'(want.speed_step), 32'(m_speed_step));
                    compare_field("clock_update", 32'(want.clock_update), 32'(m_clock_update));
                    compare_field("clock_axis", 32'(want.clock_axis), 32'(m_clock_axis));
                    compare_field("clock_value", 32'(want.clock_value), 32'(m_clock_value));
                    compare_field("elapsed_ms", want.elapsed_ms, m_elapsed_ms);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("motion_ramp_step_scheduler_core: mismatch");
            $finish;
        end
    end

    task automatic cfg_write(mrss_pkg::cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_idx <= idx;
        cfg_wr_data <= val;
        case (idx)
            mrss_pkg::CFG_ROTATE_MODE:       cfg_mirror.rotate_mode = val[0];
            mrss_pkg::CFG_ROTATE_AXIS:       cfg_mirror.rotate_axis = val[1:0];
            mrss_pkg::CFG_ROTATE_STAGES:     cfg_mirror.rotate_stages = val[4:0];
            mrss_pkg::CFG_ROTATE_FULL_CLOCK: cfg_mirror.rotate_full_clock = val[15:0];
            mrss_pkg::CFG_RAMP_STEPS_TOTAL:  cfg_mirror.ramp_steps_total = val[7:0];
            mrss_pkg::CFG_RAMP_DISABLE:      cfg_mirror.ramp_disable = val[0];
            mrss_pkg::CFG_DECEL_MARGIN:      cfg_mirror.decel_margin = val;
            mrss_pkg::CFG_MAX_PULSES:        cfg_mirror.max_pulses = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_cfg(mrss_pkg::cfg_t c);
        cfg_write(mrss_pkg::CFG_ROTATE_MODE, 32'(c.rotate_mode));
        cfg_write(mrss_pkg::CFG_ROTATE_AXIS, 32'(c.rotate_axis));
        cfg_write(mrss_pkg::CFG_ROTATE_STAGES, 32'(c.rotate_stages));
        cfg_write(mrss_pkg::CFG_ROTATE_FULL_CLOCK, 32'(c.rotate_full_clock));
        cfg_write(mrss_pkg::CFG_RAMP_STEPS_TOTAL, 32'(c.ramp_steps_total));
        cfg_write(mrss_pkg::CFG_RAMP_DISABLE, 32'(c.ramp_disable));
        cfg_write(mrss_pkg::CFG_DECEL_MARGIN, c.decel_margin);
        cfg_write(mrss_pkg::CFG_MAX_PULSES, c.max_pulses);
    endtask

    task automatic push_tick(mrss_pkg::item_t it);
        tick_q.push_back(it);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || ramp_result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one watched axis gets pv/tv, the rest the inverse; watch = NUM_AXES means no match
    function automatic mrss_pkg::item_t make_item(logic act, int watch, logic [31:0] pv,
                                                  logic [31:0] tv);
        mrss_pkg::item_t it;
        it.action = act;
        for (int k = 0; k < mrss_pkg::NUM_AXES; k++) begin
            it.pulses[k] = (k == watch) ? pv : ~pv;
            it.targets[k] = (k == watch) ? tv : ~tv;
        end
        return it;
    endfunction

    function automatic mrss_pkg::cfg_t pick_cfg(int p);
        mrss_pkg::cfg_t c;
        c.rotate_mode = (p % 4 == 2);
        c.rotate_axis = 2'($urandom_range(0, 3));
        c.rotate_stages = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                          5'($urandom_range(1, 16));
        c.rotate_full_clock = 16'($urandom);
        c.ramp_steps_total = 8'($urandom_range(1, 12));
        c.ramp_disable = (p == 3);
        c.max_pulses = $urandom;
        if (p == 2) begin
            c.rotate_stages = 5'd16;
            c.rotate_full_clock = 16'hffff;
        end
        if (p == 10)
            c.rotate_stages = 5'd31;
        if (p == 5)
            c.ramp_steps_total = 8'd255;
        if (p == 7)
            c.ramp_steps_total = 8'd0;
        if (p == 4)
            c.max_pulses = 32'hffff_ffff;
        if (p == 6)
            c.max_pulses = 32'd0;
        case ($urandom_range(0, 4))
            0:       c.decel_margin = 32'd0;
            1:       c.decel_margin = 32'hffff_ffff;
            2:       c.decel_margin = $urandom;
            default: c.decel_margin = c.max_pulses >> $urandom_range(1, 6);
        endcase
        return c;
    endfunction

    initial begin
        mrss_pkg::cfg_t  c;
        mrss_pkg::item_t it;
        int              count;
        int              len;
        int              w;
        int              w2;

        cfg_mirror = mrss_pkg::cfg_t'{1'b0, 2'd0, 5'd4, 16'd6666, 8'd0, 1'b0, 32'd0, 32'd0};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ramp up, hold, then decel on the first matching axis
        apply_cfg(mrss_pkg::cfg_t'{1'b0, 2'd0, 5'd4, 16'd6666, 8'd2, 1'b0, 32'd10, 32'd100});
        push_tick(make_item(1'b1, 0, 32'hffff_ffff, 32'hffff_ffff));
        push_tick(make_item(1'b0, 1, 32'd5, 32'd100));
        push_tick(make_item(1'b0, 2, 32'd50, 32'd100));
        push_tick(make_item(1'b0, 3, 32'd60, 32'd100));
        push_tick(make_item(1'b0, 0, 32'd95, 32'd100));
        push_tick(make_item(1'b0, mrss_pkg::NUM_AXES, 32'd99, 32'd100));
        push_tick(make_item(1'b0, 4, 32'd95, 32'd100));
        push_tick(make_item(1'b0, 4, 32'd100, 32'd100));
        wait_drained();

        // ramp disabled, margin equal to the maximum
        apply_cfg(mrss_pkg::cfg_t'{1'b0, 2'd0, 5'd4, 16'd6666, 8'd255, 1'b1, 32'hffff_ffff,
                                   32'hffff_ffff});
        push_tick(make_item(1'b1, 2, 32'd0, 32'd0));
        push_tick(make_item(1'b0, 2, 32'd0, 32'hffff_ffff));
        push_tick(make_item(1'b0, 4, 32'hffff_ffff, 32'hffff_ffff));
        wait_drained();

        // rotate ramp through all stages and past the last
        apply_cfg(mrss_pkg::cfg_t'{1'b1, 2'd2, 5'd4, 16'hffff, 8'd0, 1'b0, 32'd0, 32'd0});
        repeat (1) push_tick(make_item(1'b1, 0, 32'd0, 32'd0));
        repeat (4) push_tick(make_item(1'b0, 1, $urandom, $urandom));
        wait_drained();

        // no axis selected, then stage counts above sixteen, zero and one
        apply_cfg(mrss_pkg::cfg_t'{1'b1, mrss_pkg::AXIS_NONE, 5'd31, 16'h8000, 8'd0, 1'b0,
                                   32'd0, 32'd0});
        repeat (2) push_tick(make_item(1'b0, 0, $urandom, $urandom));
        wait_drained();
        apply_cfg(mrss_pkg::cfg_t'{1'b1, 2'd0, 5'd31, 16'h8000, 8'd0, 1'b0, 32'd0, 32'd0});
        push_tick(make_item(1'b0, 0, $urandom, $urandom));
        wait_drained();
        apply_cfg(mrss_pkg::cfg_t'{1'b1, 2'd1, 5'd0, 16'h8000, 8'd0, 1'b0, 32'd0, 32'd0});
        push_tick(make_item(1'b0, 0, $urandom, $urandom));
        wait_drained();
        apply_cfg(mrss_pkg::cfg_t'{1'b1, 2'd1, 5'd1, 16'h8000, 8'd0, 1'b0, 32'd0, 32'd0});
        push_tick(make_item(1'b0, 0, $urandom, $urandom));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            c = pick_cfg(p);
            send_idle_pct = (p < 4) ? 33 : (p < 8) ? 48 : 0;
            recv_idle_pct = (p < 4) ? 48 : (p < 8) ? 33 : 0;
            apply_cfg(c);
            count = 0;
            while (count < PHASE_ITEMS) begin
                for (int k = 0; k < mrss_pkg::NUM_AXES; k++) begin
                    it.pulses[k] = $urandom;
                    it.targets[k] = $urandom;
                end
                if ($urandom_range(0, 99) < 8) begin
                    // noise transaction
                    it.action = 1'($urandom_range(0, 1));
                    push_tick(it);
                    count++;
                end else begin
                    it.action = 1'b1;
                    push_tick(it);
                    count++;
                    len = c.rotate_mode ? int'(c.rotate_stages) + $urandom_range(0, 3) :
                          int'(c.ramp_steps_total) + 3 + $urandom_range(1, 12);
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(1, len);
                    w = $urandom_range(0, mrss_pkg::NUM_AXES);
                    w2 = ($urandom_range(0, 3) == 0) ?
                         $urandom_range(0, mrss_pkg::NUM_AXES - 1) : mrss_pkg::NUM_AXES;
                    for (int t = 1; t <= len; t++) begin
                        it.action = 1'b0;
                        for (int k = 0; k < mrss_pkg::NUM_AXES; k++) begin
                            it.pulses[k] = $urandom;
                            it.targets[k] = $urandom;
                        end
                        if (w2 < mrss_pkg::NUM_AXES)
                            it.targets[w2] = c.max_pulses;
                        if (w < mrss_pkg::NUM_AXES) begin
                            it.targets[w] = c.max_pulses;
                            it.pulses[w] = 32'((64'(c.max_pulses) * 64'(t)) / 64'(len));
                        end
                        push_tick(it);
                        count++;
                    end
                end
            end
            if (p == 1 || p == 9)
                hold_req_cnt++;
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("motion_ramp_step_scheduler_core: match");
        end else begin
            $display("motion_ramp_step_scheduler_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mrss_pkg.sv
rtl/mrss_step.sv
rtl/motion_ramp_step_scheduler_core.sv
tb/motion_ramp_step_scheduler_core_tb.sv
